>>> src/nrw_pkg.sv
// Shared types, constants and direction tables for the neighbour ratio weights block.
// Used by nrw_divider, neighbour_ratio_weights_core and nrw_checker; depends on nothing else.
package nrw_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 256;
  localparam int DEFAULT_PIXEL_BITS = 8;
  localparam int DEFAULT_FRAC_BITS  = 8;
  localparam int MAX_ROWS           = 4096;

  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 13;
  localparam int WIDTH_REG_BITS  = 9;
  localparam int HEIGHT_REG_BITS = 13;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 9'd128;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd128;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;

  localparam int COLUMN_BITS = 8;
  localparam int ROW_BITS    = 12;
  localparam int RATIO_BITS  = 16;
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = 16'hFFFF;

  localparam int NUM_DIRS = 8;
  localparam int DIR_BITS = 3;
  localparam logic [DIR_BITS-1:0] LAST_DIR = 3'd7;

  localparam int DIV_STEP_BITS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CENTRE,
    ST_ISSUE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } seq_state_t;

  typedef logic signed [1:0] step_t;

  // Directions in output order: up-right, right, down-right, down,
  // down-left, left, up-left, up.
  function automatic step_t dir_dy(input logic [DIR_BITS-1:0] k);
    unique case (k)
      3'd0: dir_dy = -2'sd1;
      3'd1: dir_dy = 2'sd0;
      3'd2: dir_dy = 2'sd1;
      3'd3: dir_dy = 2'sd1;
      3'd4: dir_dy = 2'sd1;
      3'd5: dir_dy = 2'sd0;
      3'd6: dir_dy = -2'sd1;
      3'd7: dir_dy = -2'sd1;
    endcase
  endfunction

  function automatic step_t dir_dx(input logic [DIR_BITS-1:0] k);
    unique case (k)
      3'd0: dir_dx = 2'sd1;
      3'd1: dir_dx = 2'sd1;
      3'd2: dir_dx = 2'sd1;
      3'd3: dir_dx = 2'sd0;
      3'd4: dir_dx = -2'sd1;
      3'd5: dir_dx = -2'sd1;
      3'd6: dir_dx = -2'sd1;
      3'd7: dir_dx = 2'sd0;
    endcase
  endfunction

endpackage

>>> src/nrw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing else.
module nrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 515
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/nrw_divider.sv
// Iterative restoring divider giving one saturated fixed-point neighbour/centre ratio.
// Retires DIV_STEP_BITS quotient bits per cycle; depends on nrw_pkg.
module nrw_divider
  import nrw_pkg::*;
#(
  parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS,
  parameter int FRAC_BITS  = DEFAULT_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PIXEL_BITS-1:0] neighbour,
  input  logic [PIXEL_BITS-1:0] centre,
  output logic                  done,
  output logic [RATIO_BITS-1:0] ratio
);

  localparam int NUM_BITS = PIXEL_BITS + FRAC_BITS;
  localparam int PAD_BITS = ((NUM_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
  localparam int STEPS    = PAD_BITS / DIV_STEP_BITS;
  localparam int CNT_BITS = $clog2(STEPS + 1);
  localparam int EXT_BITS = PAD_BITS + RATIO_BITS;

  logic                  busy;
  logic [CNT_BITS-1:0]   count;
  logic [PAD_BITS-1:0]   num;
  logic [PAD_BITS-1:0]   quo;
  logic [PAD_BITS-1:0]   num_next;
  logic [PAD_BITS-1:0]   quo_next;
  logic [PIXEL_BITS-1:0] rem;
  logic [PIXEL_BITS-1:0] rem_next;
  logic [PIXEL_BITS-1:0] divisor;
  logic [PIXEL_BITS:0]   trial;
  logic [EXT_BITS-1:0]   quo_ext;

  always_comb begin
    num_next = num;
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial    = {rem_next, num_next[PAD_BITS-1]};
      num_next = num_next << 1;
      if (trial >= {1'b0, divisor}) begin
        trial    = trial - {1'b0, divisor};
        quo_next = (quo_next << 1) | PAD_BITS'(1);
      end else begin
        quo_next = quo_next << 1;
      end
      rem_next = trial[PIXEL_BITS-1:0];
    end
  end

  assign done    = busy && (count == CNT_BITS'(1));
  assign quo_ext = EXT_BITS'(quo_next);
  assign ratio   = (quo_ext > EXT_BITS'(RATIO_MAX)) ? RATIO_MAX : quo_ext[RATIO_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_BITS'(STEPS);
    end else if (busy) begin
      count <= count - CNT_BITS'(1);
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num     <= PAD_BITS'(neighbour) << FRAC_BITS;
      quo     <= '0;
      rem     <= '0;
      divisor <= centre;
    end else if (busy) begin
      num <= num_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

>>> src/neighbour_ratio_weights_core.sv
// Top level of the neighbour ratio weights block: sequencer, line store and output register.
// Depends on nrw_pkg, nrw_ram and nrw_divider.
//
// Pixels enter in raster order on the input channel (in_valid, in_stall, command,
// pixel_value); command 1 is a drain step that flushes one pending result once the
// whole frame is in. Each result carries the centre position and eight Q8.8
// neighbour/centre ratios; it leaves one row and one column behind the input.
// The configuration port (cfg_write, cfg_index, cfg_data) sets image_width and
// image_height, and every write restarts the frame.
// One item is processed at a time. An item that gives no result leaves after the
// decide state. An item that gives a result then has its centre read and visits
// each neighbour in turn: one outside the frame, or any neighbour when the centre
// is zero, gets its weight without a division; any other takes one line-store
// read and the shared divider, which retires four quotient bits per cycle.
// The finished result sits in an output register, so the next item is taken
// while the receiver stalls; the sequencer only waits on it when a new result is ready
// and the register is still full. Reset clears the counters, the output valid
// and restores both registers to 128; the line store needs no clearing.
module neighbour_ratio_weights_core
  import nrw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS,
  parameter int FRAC_BITS  = DEFAULT_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [PIXEL_BITS-1:0]     pixel_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COLUMN_BITS-1:0]    out_column,
  output logic [ROW_BITS-1:0]       out_row,
  output logic [RATIO_BITS-1:0]     ratio_up_right,
  output logic [RATIO_BITS-1:0]     ratio_right,
  output logic [RATIO_BITS-1:0]     ratio_down_right,
  output logic [RATIO_BITS-1:0]     ratio_down,
  output logic [RATIO_BITS-1:0]     ratio_down_left,
  output logic [RATIO_BITS-1:0]     ratio_left,
  output logic [RATIO_BITS-1:0]     ratio_up_left,
  output logic [RATIO_BITS-1:0]     ratio_up,
  output logic                      zero_centre,
  output logic                      frame_last
);

  localparam int DEPTH  = 2 * MAX_WIDTH + 3;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = AW + 2;
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int XW     = EW + WIDTH_REG_BITS;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_ROWS + 1);
  localparam int CEXT_W = COL_W + COLUMN_BITS;

  seq_state_t state;
  seq_state_t state_next;

  logic [WIDTH_REG_BITS-1:0]  cfg_width;
  logic [HEIGHT_REG_BITS-1:0] cfg_height;
  logic [XW-1:0]              width_ext;
  logic [EW-1:0]              eff_w;
  logic [HEIGHT_REG_BITS-1:0] eff_h;
  logic [CNT_W-1:0]           total;

  logic [CNT_W-1:0] in_count;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] emit_pos;
  logic [AW-1:0]    emit_addr;
  logic [COL_W-1:0] emit_col;
  logic [ROW_BITS-1:0] emit_row;

  logic                  cmd_reg;
  logic [PIXEL_BITS-1:0] pix_reg;
  logic [PIXEL_BITS-1:0] centre;
  logic [DIR_BITS-1:0]   dir;
  logic [RATIO_BITS-1:0] ratio_q [NUM_DIRS];

  logic [CNT_W-1:0] count_next;
  logic [CNT_W:0]   emit_need;
  logic             is_pixel;
  logic             emit_now;
  logic             drain_ok;
  logic             take_result;
  logic             frame_last_now;
  logic             col_last;
  logic             centre_zero;

  step_t            dy;
  step_t            dx;
  logic             row_ok;
  logic             col_ok;
  logic             nb_in_frame;
  logic             nb_div;
  logic signed [SW-1:0] nb_sum;
  logic [AW-1:0]    nb_addr;

  logic             accept;
  logic             out_free;
  logic             load_out;
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [PIXEL_BITS-1:0] ram_rd_data;
  logic             div_start;
  logic             div_done;
  logic [RATIO_BITS-1:0] div_ratio;
  logic [CEXT_W-1:0] col_ext;

  // Effective frame size after clamping the registers to their legal ranges.
  always_comb begin
    width_ext = XW'(cfg_width);
    if (cfg_width == '0) begin
      eff_w = EW'(1);
    end else if (width_ext > XW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext[EW-1:0];
    end
    if (cfg_height == '0) begin
      eff_h = HEIGHT_REG_BITS'(1);
    end else if (cfg_height > HEIGHT_REG_BITS'(MAX_ROWS)) begin
      eff_h = HEIGHT_REG_BITS'(MAX_ROWS);
    end else begin
      eff_h = cfg_height;
    end
    total = CNT_W'(eff_w) * CNT_W'(eff_h);
  end

  always_comb begin
    count_next     = in_count + CNT_W'(1);
    emit_need      = (CNT_W + 1)'(emit_pos) + (CNT_W + 1)'(eff_w) + (CNT_W + 1)'(2);
    is_pixel       = (cmd_reg == CMD_PIXEL) && (in_count < total);
    emit_now       = emit_need <= (CNT_W + 1)'(count_next);
    drain_ok       = (in_count == total) && (emit_pos < total);
    take_result    = is_pixel ? emit_now : drain_ok;
    frame_last_now = (emit_pos + CNT_W'(1)) == total;
    col_last       = (EW'(emit_col) + EW'(1)) == eff_w;
    centre_zero    = centre == '0;
  end

  // Frame test and line-store address of the current neighbour.
  always_comb begin
    dy = dir_dy(dir);
    dx = dir_dx(dir);
    if (dy == -2'sd1) begin
      row_ok = emit_row != '0;
    end else if (dy == 2'sd1) begin
      row_ok = (HEIGHT_REG_BITS'(emit_row) + HEIGHT_REG_BITS'(1)) < eff_h;
    end else begin
      row_ok = 1'b1;
    end
    if (dx == -2'sd1) begin
      col_ok = emit_col != '0;
    end else if (dx == 2'sd1) begin
      col_ok = (EW'(emit_col) + EW'(1)) < eff_w;
    end else begin
      col_ok = 1'b1;
    end
    nb_in_frame = row_ok && col_ok;
    nb_div      = nb_in_frame && !centre_zero;

    nb_sum = $signed(SW'(emit_addr)) + SW'(dx);
    if (dy == 2'sd1) begin
      nb_sum = nb_sum + $signed(SW'(eff_w));
    end else if (dy == -2'sd1) begin
      nb_sum = nb_sum - $signed(SW'(eff_w));
    end
    if (nb_sum < $signed(SW'(0))) begin
      nb_sum = nb_sum + $signed(SW'(DEPTH));
    end else if (nb_sum >= $signed(SW'(DEPTH))) begin
      nb_sum = nb_sum - $signed(SW'(DEPTH));
    end
    nb_addr = nb_sum[AW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = take_result ? ST_CENTRE : ST_IDLE;
      end
      ST_CENTRE: begin
        state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (nb_div) begin
          state_next = ST_START;
        end else if (dir == LAST_DIR) begin
          state_next = ST_DONE;
        end
      end
      ST_START: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_next = (dir == LAST_DIR) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = rst || (state != ST_IDLE);
    accept      = in_valid && !in_stall;
    out_free    = !out_valid || !out_stall;
    load_out    = (state == ST_DONE) && out_free;
    ram_wr_en   = (state == ST_DECIDE) && is_pixel;
    ram_rd_en   = ((state == ST_DECIDE) && take_result) || ((state == ST_ISSUE) && nb_div);
    ram_rd_addr = (state == ST_DECIDE) ? emit_addr : nb_addr;
    div_start   = state == ST_START;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
      in_count   <= '0;
      wr_addr    <= '0;
      emit_pos   <= '0;
      emit_addr  <= '0;
      emit_col   <= '0;
      emit_row   <= '0;
      dir        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  cfg_width  <= cfg_data[WIDTH_REG_BITS-1:0];
          REG_IMAGE_HEIGHT: cfg_height <= cfg_data;
        endcase
      end
      if (cfg_write || (load_out && frame_last_now)) begin
        in_count  <= '0;
        wr_addr   <= '0;
        emit_pos  <= '0;
        emit_addr <= '0;
        emit_col  <= '0;
        emit_row  <= '0;
      end else begin
        if (ram_wr_en) begin
          in_count <= count_next;
          wr_addr  <= (wr_addr == AW'(DEPTH - 1)) ? '0 : wr_addr + AW'(1);
        end
        if (load_out) begin
          emit_pos  <= emit_pos + CNT_W'(1);
          emit_addr <= (emit_addr == AW'(DEPTH - 1)) ? '0 : emit_addr + AW'(1);
          if (col_last) begin
            emit_col <= '0;
            emit_row <= emit_row + ROW_BITS'(1);
          end else begin
            emit_col <= emit_col + COL_W'(1);
          end
        end
      end
      if (state == ST_CENTRE) begin
        dir <= '0;
      end else if ((state == ST_ISSUE && !nb_div) || (state == ST_WAIT && div_done)) begin
        dir <= dir + DIR_BITS'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign col_ext = CEXT_W'(emit_col);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg <= command;
      pix_reg <= pixel_value;
    end
    if (state == ST_CENTRE) begin
      centre <= ram_rd_data;
    end
    if (state == ST_ISSUE && !nb_div) begin
      ratio_q[dir] <= nb_in_frame ? RATIO_MAX : '0;
    end else if (state == ST_WAIT && div_done) begin
      ratio_q[dir] <= div_ratio;
    end
    if (load_out) begin
      out_column       <= col_ext[COLUMN_BITS-1:0];
      out_row          <= emit_row;
      ratio_up_right   <= ratio_q[0];
      ratio_right      <= ratio_q[1];
      ratio_down_right <= ratio_q[2];
      ratio_down       <= ratio_q[3];
      ratio_down_left  <= ratio_q[4];
      ratio_left       <= ratio_q[5];
      ratio_up_left    <= ratio_q[6];
      ratio_up         <= ratio_q[7];
      zero_centre      <= centre_zero;
      frame_last       <= frame_last_now;
    end
  end

  nrw_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(wr_addr),
    .wr_data(pix_reg),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  nrw_divider #(
    .PIXEL_BITS(PIXEL_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .neighbour(ram_rd_data),
    .centre   (centre),
    .done     (div_done),
    .ratio    (div_ratio)
  );

endmodule

>>> src/nrw_checker.sv
// Port-level assertions for the neighbour ratio weights block, bound to the top level.
// Depends on nrw_pkg.
module nrw_checker
  import nrw_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [RATIO_BITS-1:0] ratio_up_right,
  input logic [RATIO_BITS-1:0] ratio_right,
  input logic [RATIO_BITS-1:0] ratio_down_right,
  input logic [RATIO_BITS-1:0] ratio_down,
  input logic [RATIO_BITS-1:0] ratio_down_left,
  input logic [RATIO_BITS-1:0] ratio_left,
  input logic [RATIO_BITS-1:0] ratio_up_left,
  input logic [RATIO_BITS-1:0] ratio_up,
  input logic                  zero_centre,
  input logic                  frame_last
);

  // A stalled result stays valid and keeps its right, down, up and left weights.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ratio_right) && $stable(ratio_down)
      && $stable(ratio_up) && $stable(ratio_left))
    else $error("stalled result changed");

  // The block works on one item at a time, so a transfer is always followed by a stall.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in two consecutive cycles");

  // With a zero centre every weight is either saturated or outside the frame.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_centre |->
      (ratio_up_right == RATIO_MAX || ratio_up_right == '0) &&
      (ratio_right == RATIO_MAX || ratio_right == '0) &&
      (ratio_down_right == RATIO_MAX || ratio_down_right == '0) &&
      (ratio_down == RATIO_MAX || ratio_down == '0) &&
      (ratio_down_left == RATIO_MAX || ratio_down_left == '0) &&
      (ratio_left == RATIO_MAX || ratio_left == '0) &&
      (ratio_up_left == RATIO_MAX || ratio_up_left == '0) &&
      (ratio_up == RATIO_MAX || ratio_up == '0))
    else $error("zero centre with an unsaturated weight");

  // The last pixel of a frame has no right, lower or lower-corner neighbour.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      ratio_right == '0 && ratio_down_right == '0 && ratio_down == '0 && ratio_down_left == '0)
    else $error("last pixel has a weight outside the frame");

endmodule

bind neighbour_ratio_weights_core nrw_checker u_nrw_checker (.*);
